// ===== design/pixel_gain_half_precision_defines.svh =====
// Assertion macros for the pixel gain block
`ifndef PIXEL_GAIN_HALF_PRECISION_DEFINES_SVH
`define PIXEL_GAIN_HALF_PRECISION_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked only outside reset
`define PGH_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pixel gain assertion failed");
// Checked at every edge, reset included
`define PGH_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pixel gain assertion failed");
`else
`define PGH_ASSERT(lbl, prop)
`define PGH_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== design/pgh_pkg.sv =====
package pgh_pkg;

  // binary16 layout
  localparam int FRAC_W = 10;
  localparam int EXP_W  = 5;
  localparam int SIG_W  = FRAC_W + 1;
  localparam int PIX_W  = 8;
  localparam int PROD_W = PIX_W + SIG_W;

  // value = sig * 2^(ex - EXP_BIAS_SHIFT)
  localparam logic [EXP_W-1:0] EXP_BIAS_SHIFT = 5'd25;
  localparam logic [EXP_W-1:0] EXP_SPECIAL    = 5'd31;
  localparam logic [EXP_W-1:0] EXP_SUBNORMAL  = 5'd0;
  localparam logic [PIX_W-1:0] PIX_MAX        = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [15:0]      gain_bits;
    logic             last_in;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] scaled_pixel;
    logic             last_out;
  } res_item_t;

endpackage

// ===== design/pgh_scale.sv =====
module pgh_scale (
  input  pgh_pkg::pix_item_t item,
  output pgh_pkg::res_item_t result
);
  import pgh_pkg::*;

  logic             sign;
  logic [EXP_W-1:0] expf;
  logic [EXP_W-1:0] ex;
  logic [SIG_W-1:0] sig;
  logic [PROD_W-1:0] prod;
  logic [2:0]       lsh;
  logic [23:0]      lval;
  logic [EXP_W-1:0] rsh;
  logic [EXP_W-1:0] rsh_m1;
  logic [23:0]      prodx;
  logic [23:0]      q;
  logic             rbit;
  logic             sticky;
  logic             round_up;
  logic [24:0]      q_rnd;

  // Decode the gain, subnormals use exponent one with no hidden bit
  assign sign = item.gain_bits[15];
  assign expf = item.gain_bits[14:10];
  assign ex   = (expf == EXP_SUBNORMAL) ? 5'd1 : expf;
  assign sig  = {(expf != EXP_SUBNORMAL), item.gain_bits[FRAC_W-1:0]};
  assign prod = PROD_W'(item.pixel) * PROD_W'(sig);

  // Left shift when the exponent is at or above the binary point
  assign lsh  = 3'(ex - EXP_BIAS_SHIFT);
  assign lval = 24'(prod) << lsh;

  // Right shift with round to nearest, ties to even
  assign rsh      = EXP_BIAS_SHIFT - ex;
  assign rsh_m1   = rsh - 5'd1;
  assign prodx    = 24'(prod);
  assign q        = prodx >> rsh;
  assign rbit     = prodx[rsh_m1];
  assign sticky   = |(prodx & ((24'd1 << rsh_m1) - 24'd1));
  assign round_up = rbit & (sticky | q[0]);
  assign q_rnd    = 25'(q) + 25'(round_up);

  // Special cases, then saturation
  always_comb begin
    result.last_out = item.last_in;
    if (expf == EXP_SPECIAL || sign || prod == '0) begin
      result.scaled_pixel = '0;
    end else if (ex >= EXP_BIAS_SHIFT) begin
      result.scaled_pixel = (lval > 24'(PIX_MAX)) ? PIX_MAX : lval[PIX_W-1:0];
    end else begin
      result.scaled_pixel = (q_rnd > 25'(PIX_MAX)) ? PIX_MAX : q_rnd[PIX_W-1:0];
    end
  end

endmodule

// ===== design/pixel_gain_half_precision.sv =====
// Pixel times binary16 gain, round to nearest even, saturate to 0..255.
// An accepted item passes the input register, then the result register, before res_valid rises.
// One item is accepted per cycle unless res_ready stalls the output; the single-pass scale logic sits between the two.
// Reset (rst, synchronous, active high) empties both stages; the data registers are not reset.
`include "pixel_gain_half_precision_defines.svh"

module pixel_gain_half_precision (
  input  logic               clk,
  input  logic               rst,
  input  logic               pix_valid,
  output logic               pix_ready,
  input  pgh_pkg::pix_item_t pix,
  output logic               res_valid,
  input  logic               res_ready,
  output pgh_pkg::res_item_t res
);
  import pgh_pkg::*;

  logic      s1_valid;
  pix_item_t s1_item;
  res_item_t s1_result;
  logic      s2_valid;
  res_item_t s2_item;
  logic      s2_load;

  // Stage handoff
  assign s2_load   = s1_valid && (!s2_valid || res_ready);
  assign pix_ready = !s1_valid || s2_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_ready) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_valid && pix_ready) begin
      s1_item <= pix;
    end
  end

  pgh_scale u_scale (
    .item   (s1_item),
    .result (s1_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (res_ready) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_item <= s1_result;
    end
  end

  assign res_valid = s2_valid;
  assign res       = s2_item;

  // Checks
  `PGH_ASSERT(a_load_fills_s1, (pix_valid && pix_ready) |=> s1_valid)
  `PGH_ASSERT(a_full_stall_blocks, (s1_valid && s2_valid && !res_ready) |-> !pix_ready)
  `PGH_ASSERT(a_last_follows, s2_load |=> (res.last_out == $past(s1_item.last_in)))
  `PGH_ASSERT_ALWAYS(a_reset_empties, rst |=> (!res_valid && !s1_valid))

endmodule
